>>> hw/rtl/mcmf_pkg.sv
// ----------------------------------------------------------------------------
// mcmf_pkg
// Shared types and constants of the multi-channel message fifo unit.
// ----------------------------------------------------------------------------
package mcmf_pkg;

    // default geometry
    localparam int NUM_PIPES_DEF      = 8;
    localparam int SLOTS_PER_PIPE_DEF = 32;
    localparam int SLOT_BYTES_DEF     = 64;

    // staged byte count saturates here
    localparam logic [6:0] STAGE_MAX = 7'd127;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_COUNT = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_WRITTEN   = 3'd0,
        ST_FULL      = 3'd1,
        ST_BAD_LEN   = 3'd2,
        ST_READ_BYTE = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_INFO      = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_PTR   = 2'd1,
        S_LEN   = 2'd2,
        S_BYTES = 2'd3
    } state_t;

    // pointer table access
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } ptr_cmd_t;

    // message store access
    typedef struct packed {
        logic data_we;
        logic data_re;
        logic len_we;
        logic len_re;
    } store_cmd_t;

endpackage

>>> hw/rtl/mcmf_ptr_table.sv
// ----------------------------------------------------------------------------
// mcmf_ptr_table
// Per-queue write and read slot indexes in a synchronous memory with
// registered read data; per-entry valid bits make a fresh entry read as zero.
// ----------------------------------------------------------------------------
module mcmf_ptr_table #(
    parameter int NUM_PIPES      = mcmf_pkg::NUM_PIPES_DEF,
    parameter int SLOTS_PER_PIPE = mcmf_pkg::SLOTS_PER_PIPE_DEF,
    localparam int PIPE_W        = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1,
    localparam int IDX_W         = $clog2(SLOTS_PER_PIPE)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mcmf_pkg::ptr_cmd_t  cmd,
    input  logic [PIPE_W-1:0]   addr,
    input  logic [IDX_W-1:0]    wr_wptr,
    input  logic [IDX_W-1:0]    wr_rptr,
    output logic [IDX_W-1:0]    rd_wptr,
    output logic [IDX_W-1:0]    rd_rptr
);

    logic [2*IDX_W-1:0] mem [NUM_PIPES];
    logic [NUM_PIPES-1:0] valid_reg;
    logic [2*IDX_W-1:0] rdata_reg;
    logic rvalid_reg;

    // memory array
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[addr] <= {wr_wptr, wr_rptr};
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    // valid bits and registered valid of the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en)
            begin
                valid_reg[addr] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                rvalid_reg <= valid_reg[addr];
            end
        end
    end

    // unwritten entry reads as zero
    assign rd_wptr = rvalid_reg ? rdata_reg[2*IDX_W-1:IDX_W] : '0;
    assign rd_rptr = rvalid_reg ? rdata_reg[IDX_W-1:0] : '0;

endmodule

>>> hw/rtl/mcmf_msg_store.sv
// ----------------------------------------------------------------------------
// mcmf_msg_store
// Payload byte memory and per-slot length memory, one write and one read
// port each, read data registered.
// ----------------------------------------------------------------------------
module mcmf_msg_store #(
    parameter int NUM_PIPES      = mcmf_pkg::NUM_PIPES_DEF,
    parameter int SLOTS_PER_PIPE = mcmf_pkg::SLOTS_PER_PIPE_DEF,
    parameter int SLOT_BYTES     = mcmf_pkg::SLOT_BYTES_DEF,
    localparam int SLOT_DEPTH    = NUM_PIPES * SLOTS_PER_PIPE,
    localparam int DATA_DEPTH    = SLOT_DEPTH * SLOT_BYTES,
    localparam int SLOT_W        = $clog2(SLOT_DEPTH),
    localparam int ADDR_W        = $clog2(DATA_DEPTH)
) (
    input  logic                 clk,
    input  mcmf_pkg::store_cmd_t cmd,
    input  logic [ADDR_W-1:0]    data_addr,
    input  logic [7:0]           data_wdata,
    output logic [7:0]           data_rdata,
    input  logic [SLOT_W-1:0]    len_addr,
    input  logic [5:0]           len_wdata,
    output logic [5:0]           len_rdata
);

    logic [7:0] data_mem [DATA_DEPTH];
    logic [5:0] len_mem [SLOT_DEPTH];
    logic [7:0] data_rdata_reg;
    logic [5:0] len_rdata_reg;

    // payload bytes
    always_ff @(posedge clk)
    begin
        if (cmd.data_we)
        begin
            data_mem[data_addr] <= data_wdata;
        end
        if (cmd.data_re)
        begin
            data_rdata_reg <= data_mem[data_addr];
        end
    end

    // message lengths
    always_ff @(posedge clk)
    begin
        if (cmd.len_we)
        begin
            len_mem[len_addr] <= len_wdata;
        end
        if (cmd.len_re)
        begin
            len_rdata_reg <= len_mem[len_addr];
        end
    end

    assign data_rdata = data_rdata_reg;
    assign len_rdata  = len_rdata_reg;

endmodule

>>> hw/rtl/multi_channel_message_fifo_unit.sv
// ----------------------------------------------------------------------------
// multi_channel_message_fifo_unit
// Several ring queues of variable-length messages kept in on-chip memory.
// ----------------------------------------------------------------------------
// Input beats carry one operation for one queue: a message byte to write,
// a read of the oldest message, or a message count query. Result beats
// carry a status with the byte read, the message length or the count, and
// last marks the final result beat of an input beat.
// One input beat is worked on at a time; in_stall is high while it is.
// A write byte is accepted, starting the pointer table read, then the
// registered pointers are used and the byte stored; a count is answered
// from them too. A read looks up the pointer, then the length, then gives
// one result beat per cycle while out_stall is low, one per message byte,
// set by the byte memory read port. Full, empty and bad lengths give one beat.
// While out_stall is high the result register holds and the sequencer
// waits before the next side effect, so nothing is lost.
// Reset clears the queue pointers through per-queue valid bits at once;
// no clearing pass runs, and the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module multi_channel_message_fifo_unit #(
    parameter int NUM_PIPES      = mcmf_pkg::NUM_PIPES_DEF,
    parameter int SLOTS_PER_PIPE = mcmf_pkg::SLOTS_PER_PIPE_DEF,
    parameter int SLOT_BYTES     = mcmf_pkg::SLOT_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] operation,
    input  logic [2:0] pipe,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic [5:0] max_len,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] status,
    output logic [7:0] data_byte_res,
    output logic [5:0] length,
    output logic [4:0] count,
    output logic       last
);

    localparam int PIPE_W     = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
    localparam int IDX_W      = $clog2(SLOTS_PER_PIPE);
    localparam int SLOT_DEPTH = NUM_PIPES * SLOTS_PER_PIPE;
    localparam int SLOT_W     = $clog2(SLOT_DEPTH);
    localparam int ADDR_W     = $clog2(SLOT_DEPTH * SLOT_BYTES);
    localparam int MAX_STORE  = SLOT_BYTES - 2;

    mcmf_pkg::state_t state_reg, state_next;
    logic [1:0]   op_reg, op_next;
    logic [2:0]   pipe_reg, pipe_next;
    logic [7:0]   byte_reg, byte_next;
    logic         last_in_reg, last_in_next;
    logic [5:0]   max_len_reg, max_len_next;
    logic [6:0]   staged_count_reg, staged_count_next;
    logic [2:0]   staged_pipe_reg, staged_pipe_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [5:0]   len_reg, len_next;
    logic [5:0]   idx_reg, idx_next;

    logic         out_valid_reg, out_valid_next;
    logic [2:0]   out_status_reg, out_status_next;
    logic [7:0]   out_data_reg, out_data_next;
    logic [5:0]   out_length_reg, out_length_next;
    logic [4:0]   out_count_reg, out_count_next;
    logic         out_last_reg, out_last_next;

    mcmf_pkg::ptr_cmd_t   ptr_cmd;
    mcmf_pkg::store_cmd_t store_cmd;
    logic [PIPE_W-1:0] ptr_addr;
    logic [IDX_W-1:0]  ptr_wr_wptr, ptr_wr_rptr, wptr, rptr, wptr_inc, rptr_inc;
    logic [ADDR_W-1:0] data_addr;
    logic [SLOT_W-1:0] len_addr, slot_w, slot_r;
    logic [7:0]   data_rdata;
    logic [5:0]   len_rdata;
    logic         accept, out_free, pipe_ok, load;
    logic [6:0]   stage_n, stage_len;
    logic [IDX_W:0] diff;
    logic         len_bad;

    // pointer table
    mcmf_ptr_table #(
        .NUM_PIPES      (NUM_PIPES),
        .SLOTS_PER_PIPE (SLOTS_PER_PIPE)
    ) u_ptr (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (ptr_cmd),
        .addr    (ptr_addr),
        .wr_wptr (ptr_wr_wptr),
        .wr_rptr (ptr_wr_rptr),
        .rd_wptr (wptr),
        .rd_rptr (rptr)
    );

    // message memories
    mcmf_msg_store #(
        .NUM_PIPES      (NUM_PIPES),
        .SLOTS_PER_PIPE (SLOTS_PER_PIPE),
        .SLOT_BYTES     (SLOT_BYTES)
    ) u_store (
        .clk        (clk),
        .cmd        (store_cmd),
        .data_addr  (data_addr),
        .data_wdata (byte_reg),
        .data_rdata (data_rdata),
        .len_addr   (len_addr),
        .len_wdata  (stage_len[5:0]),
        .len_rdata  (len_rdata)
    );

    // handshake
    assign in_stall = (state_reg != mcmf_pkg::S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // derived values of the item in work
    assign pipe_ok   = (32'(pipe_reg) < 32'(NUM_PIPES));
    assign wptr_inc  = (32'(wptr) == SLOTS_PER_PIPE - 1) ? '0 : IDX_W'(wptr + 1'b1);
    assign rptr_inc  = (32'(rptr) == SLOTS_PER_PIPE - 1) ? '0 : IDX_W'(rptr + 1'b1);
    assign slot_w    = SLOT_W'(32'(pipe_reg) * SLOTS_PER_PIPE + 32'(wptr));
    assign slot_r    = SLOT_W'(32'(pipe_reg) * SLOTS_PER_PIPE + 32'(rptr));
    assign stage_n   = (staged_count_reg != 7'd0 && staged_pipe_reg != pipe_reg) ?
                       7'd0 : staged_count_reg;
    assign stage_len = (stage_n == mcmf_pkg::STAGE_MAX) ? mcmf_pkg::STAGE_MAX :
                       7'(stage_n + 7'd1);
    assign diff      = (wptr >= rptr) ? (IDX_W+1)'({1'b0, wptr} - {1'b0, rptr}) :
                       (IDX_W+1)'(32'(wptr) + SLOTS_PER_PIPE - 32'(rptr));
    assign len_bad   = (len_rdata == 6'd0) || (len_rdata > max_len_reg) ||
                       (32'(len_rdata) > MAX_STORE);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= mcmf_pkg::S_IDLE;
            staged_count_reg <= '0;
            staged_pipe_reg  <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            staged_count_reg <= staged_count_next;
            staged_pipe_reg  <= staged_pipe_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        pipe_reg       <= pipe_next;
        byte_reg       <= byte_next;
        last_in_reg    <= last_in_next;
        max_len_reg    <= max_len_next;
        slot_reg       <= slot_next;
        len_reg        <= len_next;
        idx_reg        <= idx_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_length_reg <= out_length_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    // sequencer: next state, memory accesses and result beats
    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        pipe_next         = pipe_reg;
        byte_next         = byte_reg;
        last_in_next      = last_in_reg;
        max_len_next      = max_len_reg;
        staged_count_next = staged_count_reg;
        staged_pipe_next  = staged_pipe_reg;
        slot_next         = slot_reg;
        len_next          = len_reg;
        idx_next          = idx_reg;
        load              = 1'b0;
        out_status_next   = out_status_reg;
        out_data_next     = out_data_reg;
        out_length_next   = out_length_reg;
        out_count_next    = out_count_reg;
        out_last_next     = out_last_reg;
        ptr_cmd           = '0;
        store_cmd         = '0;
        ptr_addr          = PIPE_W'(pipe_reg);
        ptr_wr_wptr       = wptr;
        ptr_wr_rptr       = rptr;
        data_addr         = ADDR_W'(32'(slot_w) * SLOT_BYTES + 32'(stage_n));
        len_addr          = slot_w;

        case (state_reg)
            mcmf_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next       = operation;
                    pipe_next     = pipe;
                    byte_next     = data_byte;
                    last_in_next  = last_byte;
                    max_len_next  = max_len;
                    ptr_addr      = PIPE_W'(pipe);
                    ptr_cmd.rd_en = 1'b1;
                    state_next    = mcmf_pkg::S_PTR;
                end
            end

            mcmf_pkg::S_PTR:
            begin
                if (out_free)
                begin
                    state_next      = mcmf_pkg::S_IDLE;
                    out_data_next   = 8'd0;
                    out_length_next = 6'd0;
                    out_count_next  = 5'd0;
                    out_last_next   = 1'b1;
                    case (op_reg)
                        mcmf_pkg::OP_WRITE:
                        begin
                            staged_pipe_next = pipe_reg;
                            if (!pipe_ok)
                            begin
                                staged_count_next = 7'd0;
                                if (last_in_reg)
                                begin
                                    load            = 1'b1;
                                    out_status_next = mcmf_pkg::ST_FULL;
                                end
                            end
                            else
                            begin
                                // stage the byte straight into the free slot
                                store_cmd.data_we = (32'(stage_n) < MAX_STORE);
                                staged_count_next = stage_len;
                                if (last_in_reg)
                                begin
                                    staged_count_next = 7'd0;
                                    load              = 1'b1;
                                    if (32'(stage_len) >= MAX_STORE)
                                    begin
                                        out_status_next = mcmf_pkg::ST_BAD_LEN;
                                    end
                                    else if (wptr_inc == rptr)
                                    begin
                                        out_status_next = mcmf_pkg::ST_FULL;
                                    end
                                    else
                                    begin
                                        // commit the message
                                        store_cmd.len_we = 1'b1;
                                        ptr_cmd.wr_en    = 1'b1;
                                        ptr_wr_wptr      = wptr_inc;
                                        out_status_next  = mcmf_pkg::ST_WRITTEN;
                                    end
                                end
                            end
                        end

                        mcmf_pkg::OP_READ:
                        begin
                            if (!pipe_ok || wptr == rptr)
                            begin
                                load            = 1'b1;
                                out_status_next = mcmf_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                // pop the slot and fetch its length
                                ptr_cmd.wr_en    = 1'b1;
                                ptr_wr_rptr      = rptr_inc;
                                store_cmd.len_re = 1'b1;
                                len_addr         = slot_r;
                                slot_next        = slot_r;
                                state_next       = mcmf_pkg::S_LEN;
                            end
                        end

                        mcmf_pkg::OP_COUNT:
                        begin
                            load            = 1'b1;
                            out_status_next = mcmf_pkg::ST_INFO;
                            out_count_next  = pipe_ok ? 5'(diff) : 5'd0;
                        end

                        default:
                        begin
                            state_next = mcmf_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            mcmf_pkg::S_LEN:
            begin
                if (len_bad)
                begin
                    // discard, report the length
                    if (out_free)
                    begin
                        load            = 1'b1;
                        out_status_next = mcmf_pkg::ST_INFO;
                        out_data_next   = 8'd0;
                        out_length_next = len_rdata;
                        out_count_next  = 5'd0;
                        out_last_next   = 1'b1;
                        state_next      = mcmf_pkg::S_IDLE;
                    end
                end
                else
                begin
                    store_cmd.data_re = 1'b1;
                    data_addr         = ADDR_W'(32'(slot_reg) * SLOT_BYTES);
                    len_next          = len_rdata;
                    idx_next          = 6'd0;
                    state_next        = mcmf_pkg::S_BYTES;
                end
            end

            mcmf_pkg::S_BYTES:
            begin
                // one byte per beat, next read issued as this one leaves
                if (out_free)
                begin
                    load            = 1'b1;
                    out_status_next = mcmf_pkg::ST_READ_BYTE;
                    out_data_next   = data_rdata;
                    out_length_next = len_reg;
                    out_count_next  = 5'd0;
                    out_last_next   = (6'(idx_reg + 6'd1) == len_reg);
                    if (6'(idx_reg + 6'd1) == len_reg)
                    begin
                        state_next = mcmf_pkg::S_IDLE;
                    end
                    else
                    begin
                        store_cmd.data_re = 1'b1;
                        data_addr = ADDR_W'(32'(slot_reg) * SLOT_BYTES + 32'(idx_reg) + 1);
                        idx_next  = 6'(idx_reg + 6'd1);
                    end
                end
            end

            default:
            begin
                state_next = mcmf_pkg::S_IDLE;
            end
        endcase

        // result register
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign data_byte_res = out_data_reg;
    assign length        = out_length_reg;
    assign count         = out_count_reg;
    assign last          = out_last_reg;

    // an accepted beat always goes to the pointer lookup
    a_accept_to_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == mcmf_pkg::S_PTR))
        else $error("accepted beat did not reach pointer lookup");

    // byte streaming stays inside the message
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mcmf_pkg::S_BYTES) |-> (idx_reg < len_reg))
        else $error("read index beyond message length");

    // staged bytes only ever belong to an existing queue
    a_staged_pipe_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (staged_count_reg != 7'd0) |-> (32'(staged_pipe_reg) < 32'(NUM_PIPES)))
        else $error("bytes staged for a missing queue");

    // a read byte beat carries a nonzero length
    a_read_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == mcmf_pkg::ST_READ_BYTE) |->
        (out_length_reg != 6'd0))
        else $error("read byte beat with zero length");

endmodule
